// ===== src/lpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and FSM encoding for the LRU page replacement block.
// No dependencies; used by lpr_ctrl, lpr_datapath and lru_page_replacement_top.
package lpr_pkg;

  localparam int FRAMES        = 16;
  localparam int PAGE_BITS     = 16;

  // Fixed widths of the external fields
  localparam int PAGE_FIELD_W  = 16;
  localparam int FRAME_FIELD_W = 4;
  localparam int CFG_W         = 5;
  localparam int FAULT_W       = 32;

  localparam int FIDX_W        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W        = FIDX_W;
  localparam int CNT_W         = $clog2(FRAMES + 1);
  localparam int TREE_LEAVES   = 1 << FIDX_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } lpr_state_e;

  typedef struct packed {
    logic capture;  // latch lookup of the input beat
    logic commit;   // apply update and load the output register
  } lpr_cmd_t;

  typedef struct packed {
    logic out_stall;  // output register full and not taken this cycle
  } lpr_stat_t;

endpackage

// ===== src/lru_page_replacement_top.sv =====
`timescale 1ns / 1ps
// Top level of the LRU page frame manager: sequencer plus datapath.
// Depends on lpr_pkg, lpr_ctrl and lpr_datapath.
//
//   channel   direction  handshake               payload
//   -------   ---------  ---------------------   --------------------------------------
//   in        input      in_valid_i/in_ready_o    page_number_i
//   out       output     out_valid_o/out_ready_i  hit_o, frame_index_o, evicted_valid_o,
//                                                 evicted_page_o, fault_count_o
//   cfg       input      cfg_we_i (no wait)       cfg_wdata_i = frames_in_use
//
// For each reference, the accept cycle does the parallel tag compare, empty-frame
// search and min-rank tree; the update step that follows updates ranks, page store,
// fault counter and loads the output register.
// Reset (rst_ni, async low) empties all frames, zeroes ranks and faults, and sets
// frames_in_use to 16; page contents are left as they are.
// A full output register that is not taken holds the update step, and no new
// beat is taken until that result moves into the output register.
module lru_page_replacement_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpr_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lpr_pkg::PAGE_FIELD_W-1:0]  page_number_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [lpr_pkg::FRAME_FIELD_W-1:0] frame_index_o,
  output logic                              evicted_valid_o,
  output logic [lpr_pkg::PAGE_FIELD_W-1:0]  evicted_page_o,
  output logic [lpr_pkg::FAULT_W-1:0]       fault_count_o
);

  lpr_pkg::lpr_cmd_t  cmd;
  lpr_pkg::lpr_stat_t stat;

  // sequencer: idle/accept, then update
  lpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // frame table, ranks, victim select, output register
  lpr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .page_number_i   (page_number_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

endmodule

// ===== src/lpr_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the LRU page replacement block: lookup, then update.
// Depends on lpr_pkg.
module lpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lpr_pkg::lpr_stat_t stat_i,
  output lpr_pkg::lpr_cmd_t  cmd_o
);

  lpr_pkg::lpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      lpr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lpr_pkg::ST_UPDATE;
        end
      end
      lpr_pkg::ST_UPDATE: begin
        // hold until the output register can take the result
        if (!stat_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = lpr_pkg::ST_IDLE;
        end
      end
      default: state_d = lpr_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/lpr_datapath.sv =====
`timescale 1ns / 1ps
// Frame table, recency ranks, lookup/victim select and output register.
// Depends on lpr_pkg.
module lpr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lpr_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [lpr_pkg::PAGE_FIELD_W-1:0]    page_number_i,
  input  lpr_pkg::lpr_cmd_t                   cmd_i,
  output lpr_pkg::lpr_stat_t                  stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [lpr_pkg::FRAME_FIELD_W-1:0]   frame_index_o,
  output logic                                evicted_valid_o,
  output logic [lpr_pkg::PAGE_FIELD_W-1:0]    evicted_page_o,
  output logic [lpr_pkg::FAULT_W-1:0]         fault_count_o
);

  localparam int NF = lpr_pkg::FRAMES;
  localparam int IW = lpr_pkg::FIDX_W;
  localparam int RW = lpr_pkg::RANK_W;
  localparam int CW = lpr_pkg::CNT_W;
  localparam int PW = lpr_pkg::PAGE_BITS;
  localparam int TL = lpr_pkg::TREE_LEAVES;

  typedef struct packed {
    logic          ok;
    logic [IW-1:0] idx;
    logic [RW-1:0] rank;
  } node_t;

  // architectural state
  logic [PW-1:0]                 frame_page_q [NF];
  logic [NF-1:0]                 frame_valid_q;
  logic [RW-1:0]                 rank_q [NF];
  logic [CW-1:0]                 valid_cnt_q;
  logic [lpr_pkg::FAULT_W-1:0]   faults_q;
  logic [lpr_pkg::CFG_W-1:0]     cfg_q;

  // lookup results held between the two steps
  logic [PW-1:0] page_q;
  logic [IW-1:0] sel_q;
  logic          found_q;
  logic          evict_q;

  // output register
  logic                               out_valid_q;
  logic                               hit_q;
  logic [lpr_pkg::FRAME_FIELD_W-1:0]  frame_idx_q;
  logic                               ev_valid_q;
  logic [lpr_pkg::PAGE_FIELD_W-1:0]   ev_page_q;
  logic [lpr_pkg::FAULT_W-1:0]        fault_out_q;

  // combinational lookup
  logic [PW-1:0] page_in;
  logic [CW-1:0] n_eff;
  logic [NF-1:0] active;
  logic [IW-1:0] hit_idx, empty_idx, sel_d;
  logic          hit_any, empty_any;
  node_t         tree [2*TL];

  assign page_in = PW'(page_number_i);

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CW'(1);
    end else if (int'(cfg_q) > NF) begin
      n_eff = CW'(NF);
    end else begin
      n_eff = CW'(cfg_q);
    end
    for (int f = 0; f < NF; f++) begin
      active[f] = (f < int'(n_eff));
    end
  end

  // lowest-numbered active hit and lowest-numbered active empty frame
  always_comb begin
    hit_idx   = '0;
    hit_any   = 1'b0;
    empty_idx = '0;
    empty_any = 1'b0;
    for (int f = NF - 1; f >= 0; f--) begin
      if (active[f] && frame_valid_q[f] && (frame_page_q[f] == page_in)) begin
        hit_idx = IW'(f);
        hit_any = 1'b1;
      end
      if (active[f] && !frame_valid_q[f]) begin
        empty_idx = IW'(f);
        empty_any = 1'b1;
      end
    end
  end

  // min-rank tree over active frames, lower index wins ties
  always_comb begin
    for (int i = 0; i < TL; i++) begin
      tree[TL + i].ok   = (i < NF) ? active[i] : 1'b0;
      tree[TL + i].idx  = IW'(i);
      tree[TL + i].rank = (i < NF) ? rank_q[i] : '0;
    end
    for (int k = TL - 1; k >= 1; k--) begin
      if (tree[2*k].ok && (!tree[2*k+1].ok || (tree[2*k].rank <= tree[2*k+1].rank))) begin
        tree[k] = tree[2*k];
      end else begin
        tree[k] = tree[2*k+1];
      end
    end
    tree[0] = tree[1];
  end

  always_comb begin
    if (hit_any) begin
      sel_d = hit_idx;
    end else if (empty_any) begin
      sel_d = empty_idx;
    end else begin
      sel_d = tree[0].idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q  <= page_in;
      sel_q   <= sel_d;
      found_q <= hit_any;
      evict_q <= !hit_any && !empty_any;
    end
  end

  // update step
  logic          sel_valid;
  logic [RW-1:0] sel_rank;
  logic [RW-1:0] new_rank;
  logic [lpr_pkg::FAULT_W-1:0] faults_d;

  assign sel_valid = frame_valid_q[sel_q];
  assign sel_rank  = rank_q[sel_q];
  assign new_rank  = RW'(valid_cnt_q - CW'(sel_valid));

  always_comb begin
    faults_d = faults_q;
    if (!found_q && (faults_q != '1)) begin
      faults_d = faults_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      valid_cnt_q   <= '0;
      faults_q      <= '0;
      cfg_q         <= lpr_pkg::CFG_RESET;
      out_valid_q   <= 1'b0;
      for (int f = 0; f < NF; f++) begin
        rank_q[f] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      // a new result may replace the one leaving in the same cycle
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        faults_q    <= faults_d;
        for (int g = 0; g < NF; g++) begin
          if ((IW'(g) != sel_q) && sel_valid && frame_valid_q[g] && (rank_q[g] > sel_rank)) begin
            rank_q[g] <= rank_q[g] - 1'b1;
          end
        end
        rank_q[sel_q]        <= new_rank;
        frame_valid_q[sel_q] <= 1'b1;
        if (!sel_valid) begin
          valid_cnt_q <= valid_cnt_q + 1'b1;
        end
      end
    end
  end

  // page store and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (!found_q) begin
        frame_page_q[sel_q] <= page_q;
      end
      hit_q       <= found_q;
      frame_idx_q <= lpr_pkg::FRAME_FIELD_W'(sel_q);
      ev_valid_q  <= evict_q;
      ev_page_q   <= evict_q ? lpr_pkg::PAGE_FIELD_W'(frame_page_q[sel_q]) : '0;
      fault_out_q <= faults_d;
    end
  end

  assign stat_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_idx_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;

endmodule

// ===== tb/lru_page_replacement_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement_top: directed rows, then random refs.
// Depends on lpr_pkg and the RTL of lru_page_replacement_top; reads no files.
module lru_page_replacement_top_tb;

  localparam int FRAMES        = lpr_pkg::FRAMES;
  localparam int RANK_W        = lpr_pkg::RANK_W;
  localparam int CFG_W         = lpr_pkg::CFG_W;
  localparam int PAGE_FIELD_W  = lpr_pkg::PAGE_FIELD_W;
  localparam int FRAME_FIELD_W = lpr_pkg::FRAME_FIELD_W;
  localparam int FAULT_W       = lpr_pkg::FAULT_W;
  localparam logic [CFG_W-1:0] CFG_RESET = lpr_pkg::CFG_RESET;

  // Quiet cycles (no beat on either channel) before the run is declared hung.
  // The worst legal stretch is a long run of 80% sender gaps or receiver stalls.
  localparam int QUIET_LIMIT   = 4000;
  localparam int SEG_REFS      = 70;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 8;

  typedef enum logic [0:0] {
    ROW_REF,
    ROW_CFG
  } row_kind_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // One result beat, in the order of the output ports.
  typedef struct packed {
    logic                     hit;
    logic [FRAME_FIELD_W-1:0] frame;
    logic                     ev_valid;
    logic [PAGE_FIELD_W-1:0]  ev_page;
    logic [FAULT_W-1:0]       faults;
  } lru_result_t;

  // Directed table row: a page reference or a frames_in_use write.
  typedef struct {
    row_kind_e               kind;
    logic [PAGE_FIELD_W-1:0] value;
    bit                      typed;
    lru_result_t             want;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [PAGE_FIELD_W-1:0]  page_number_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     hit_o;
  logic [FRAME_FIELD_W-1:0] frame_index_o;
  logic                     evicted_valid_o;
  logic [PAGE_FIELD_W-1:0]  evicted_page_o;
  logic [FAULT_W-1:0]       fault_count_o;

  lru_page_replacement_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame table shadow: pages, occupancy, recency ranks (higher = more recent),
  // saturating fault total and the programmed frame count.
  // ---------------------------------------------------------------------------
  logic [PAGE_FIELD_W-1:0] shadow_page  [FRAMES];
  bit                      shadow_valid [FRAMES];
  logic [RANK_W-1:0]       shadow_rank  [FRAMES];
  logic [FAULT_W-1:0]      shadow_faults;
  logic [CFG_W-1:0]        shadow_frames;

  lru_result_t awaited_lookups[$];
  stim_row_t   directed_rows[$];
  idle_mode_e  idle_mode;
  int          mismatches;
  int          quiet_cycles;

  // frames_in_use of 0 behaves as 1, anything above FRAMES as FRAMES
  function automatic int active_frames();
    if (shadow_frames == '0) return 1;
    if (int'(shadow_frames) > FRAMES) return FRAMES;
    return int'(shadow_frames);
  endfunction

  // Apply one reference to the shadow table and return the beat it produces.
  function automatic lru_result_t lru_lookup(input logic [PAGE_FIELD_W-1:0] pg);
    lru_result_t r;
    int n;
    int sel;
    int others;
    bit found;
    bit empty;
    n = active_frames();
    sel = 0;
    found = 1'b0;
    empty = 1'b0;
    r = '0;
    // lowest-numbered matching active frame wins (duplicates after re-activation)
    for (int f = 0; f < n; f++) begin
      if (!found && shadow_valid[f] && shadow_page[f] == pg) begin
        sel = f;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int f = 0; f < n; f++) begin
        if (!empty && !shadow_valid[f]) begin
          sel = f;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        // LRU victim: smallest rank, lowest index on a tie
        sel = 0;
        for (int f = 1; f < n; f++) begin
          if (shadow_rank[f] < shadow_rank[sel]) sel = f;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = shadow_page[sel];
      end
      shadow_page[sel] = pg;
      if (shadow_faults != '1) shadow_faults++;
    end
    // promote sel to most recent, closing the gap it leaves
    if (shadow_valid[sel]) begin
      for (int g = 0; g < FRAMES; g++) begin
        if (g != sel && shadow_valid[g] && shadow_rank[g] > shadow_rank[sel]) begin
          shadow_rank[g]--;
        end
      end
    end
    others = 0;
    for (int g = 0; g < FRAMES; g++) begin
      if (g != sel && shadow_valid[g]) others++;
    end
    shadow_valid[sel] = 1'b1;
    shadow_rank[sel]  = RANK_W'(others);
    r.hit    = found;
    r.frame  = FRAME_FIELD_W'(sel);
    r.faults = shadow_faults;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_ref(input logic [PAGE_FIELD_W-1:0] pg);
    stim_row_t row;
    row.kind  = ROW_REF;
    row.value = pg;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_ref_typed(input logic [PAGE_FIELD_W-1:0] pg, input logic hit,
                                        input int frame, input logic ev_valid,
                                        input logic [PAGE_FIELD_W-1:0] ev_page,
                                        input int faults);
    stim_row_t row;
    row.kind           = ROW_REF;
    row.value          = pg;
    row.typed          = 1'b1;
    row.want.hit       = hit;
    row.want.frame     = FRAME_FIELD_W'(frame);
    row.want.ev_valid  = ev_valid;
    row.want.ev_page   = ev_page;
    row.want.faults    = FAULT_W'(faults);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input int frames);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.value = PAGE_FIELD_W'(frames);
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Idling
  // ---------------------------------------------------------------------------
  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 80;
      IDLE_BOTH: return $urandom_range(99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 80;
      IDLE_BOTH: return $urandom_range(99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  // Receiver: ready is re-rolled every falling edge
  always @(negedge clk_i) begin
    out_ready_i <= !receiver_stall();
  end

  // ---------------------------------------------------------------------------
  // Drivers. Both enter and leave at a falling edge. send_ref leaves valid high
  // so back-to-back beats never see valid dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_ref(input logic [PAGE_FIELD_W-1:0] pg, input bit typed,
                          input lru_result_t typed_want);
    lru_result_t r;
    if (sender_gap()) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (sender_gap());
    end
    in_valid_i    <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (!in_ready_o);
    // beat taken on this edge: advance the shadow table right here
    r = lru_lookup(pg);
    awaited_lookups.push_back(typed ? typed_want : r);
    @(negedge clk_i);
  endtask

  // Register writes only with nothing in flight: one result per ref, so an
  // empty queue means the block is idle.
  task automatic write_frames(input logic [CFG_W-1:0] frames);
    in_valid_i <= 1'b0;
    while (awaited_lookups.size() != 0) @(negedge clk_i);
    cfg_wdata_i <= frames;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    shadow_frames = frames;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [FAULT_W-1:0] want,
                                      input logic [FAULT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    lru_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] result beat with nothing outstanding", $realtime);
        end
      end else begin
        want = awaited_lookups.pop_front();
        check_field("hit", FAULT_W'(want.hit), FAULT_W'(hit_o));
        check_field("frame_index", FAULT_W'(want.frame), FAULT_W'(frame_index_o));
        check_field("evicted_valid", FAULT_W'(want.ev_valid), FAULT_W'(evicted_valid_o));
        check_field("evicted_page", FAULT_W'(want.ev_page), FAULT_W'(evicted_page_o));
        check_field("fault_count", want.faults, fault_count_o);
      end
    end
  end

  // Watchdog: any beat on either channel counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lru_page_replacement_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int cfg_plan[10];
    logic [PAGE_FIELD_W-1:0] page_pool[$];
    logic [PAGE_FIELD_W-1:0] pg;
    int pool_size;
    int frames;
    cfg_plan = '{16, 4, 1, 0, 31, 8, -1, 2, 16, -1};
    idle_mode     = IDLE_NONE;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    page_number_i = '0;
    for (int f = 0; f < FRAMES; f++) begin
      shadow_page[f]  = '0;
      shadow_valid[f] = 1'b0;
      shadow_rank[f]  = '0;
    end
    shadow_faults = '0;
    shadow_frames = CFG_RESET;

    // Directed rows. Typed values follow by hand from the LRU rules.
    add_ref_typed(16'h0000, 1'b0, 0, 1'b0, 16'h0000, 1);   // cold miss, first empty frame
    add_ref_typed(16'hFFFF, 1'b0, 1, 1'b0, 16'h0000, 2);   // all-ones page
    add_ref_typed(16'h0000, 1'b1, 0, 1'b0, 16'h0000, 2);   // hit, frame 0 now MRU
    add_cfg(2);
    add_ref_typed(16'h1234, 1'b0, 1, 1'b1, 16'hFFFF, 3);   // both full: evict LRU frame 1
    add_ref_typed(16'h5678, 1'b0, 0, 1'b1, 16'h0000, 4);   // then frame 0 is LRU
    add_cfg(0);                                            // zero acts as one frame
    add_ref_typed(16'h1234, 1'b0, 0, 1'b1, 16'h5678, 5);   // frame 1 is not searched
    add_cfg(2);                                            // frames 0 and 1 now both hold 0x1234
    add_ref_typed(16'h1234, 1'b1, 0, 1'b0, 16'h0000, 5);   // duplicate: lowest frame reports
    add_cfg(31);                                           // above range acts as 16
    add_ref_typed(16'hAAAA, 1'b0, 2, 1'b0, 16'h0000, 6);
    add_ref_typed(16'h5555, 1'b0, 3, 1'b0, 16'h0000, 7);
    add_ref(16'h8001);
    add_cfg(1);
    add_ref(16'h0001);
    add_cfg(16);
    add_ref(16'h0001);
    add_ref(16'h5555);
    add_ref(16'h1234);
    add_ref(16'h7FFF);
    add_ref(16'h8000);
    add_ref(16'h00FF);
    add_ref(16'hFF00);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_frames(CFG_W'(directed_rows[i].value));
      end else begin
        send_ref(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random segments: each picks a frame count and an idling mode. Most refs
    // come from a working set a little larger than the active frames, so hits,
    // fills and evictions all show up; the rest are arbitrary pages.
    foreach (cfg_plan[s]) begin
      idle_mode = idle_mode_e'(s % 4);
      frames = (cfg_plan[s] < 0) ? int'($urandom_range(31)) : cfg_plan[s];
      write_frames(CFG_W'(frames));
      pool_size = active_frames() + int'($urandom_range(1, 6));
      page_pool.delete();
      for (int k = 0; k < pool_size; k++) page_pool.push_back(PAGE_FIELD_W'($urandom));
      for (int k = 0; k < SEG_REFS; k++) begin
        if ($urandom_range(99) < 85) begin
          pg = page_pool[$urandom_range(pool_size - 1)];
        end else begin
          pg = PAGE_FIELD_W'($urandom);
        end
        send_ref(pg, 1'b0, '0);
      end
    end

    // Drain, then a short quiet window to catch stray beats
    in_valid_i <= 1'b0;
    while (awaited_lookups.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("lru_page_replacement_top_tb OK");
    end else begin
      $display("lru_page_replacement_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lpr_pkg.sv
src/lpr_ctrl.sv
src/lpr_datapath.sv
src/lru_page_replacement_top.sv
tb/lru_page_replacement_top_tb.sv
